>>> rtl/tdi_pkg.sv
// Shared widths and control structs for the trie dictionary block.
package tdi_pkg;

   localparam int SYM_BITS = 8;
   localparam int REM_BITS = 16;
   localparam int OCC_BITS = 16;
   localparam int CMP_BITS = 18;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   typedef struct packed {
      logic lookup;
      logic growing;
      logic failed;
      logic empty;
   } walk_in_type;

   typedef struct packed {
      logic failed;
      logic growing;
      logic follow;
      logic grow;
   } walk_out_type;

endpackage

>>> rtl/tdi_if.sv
// Valid/ready channel interfaces for request and response items.
interface tdi_req_if;
   logic                          valid;
   logic                          ready;
   logic                          opcode;
   logic [tdi_pkg::SYM_BITS-1:0]  symbol;
   logic [tdi_pkg::REM_BITS-1:0]  chars_remaining;

   modport source (output valid, output opcode, output symbol, output chars_remaining,
                   input ready);
   modport sink   (input valid, input opcode, input symbol, input chars_remaining,
                   output ready);
endinterface

interface tdi_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          found;
   logic [tdi_pkg::OCC_BITS-1:0]  occurrences;
   logic                          status;

   modport source (output valid, output found, output occurrences, output status,
                   input ready);
   modport sink   (input valid, input found, input occurrences, input status,
                   output ready);
endinterface

>>> rtl/tdi_step.sv
// One trie walk step: follow an edge, grow a node or fail the word.
module tdi_step #(
   parameter int NODES = 256,
   parameter int NB    = 8,
   parameter int FB    = 9
) (
   input  tdi_pkg::walk_in_type               ctl,
   input  logic [NB-1:0]                      edge_node,
   input  logic [tdi_pkg::REM_BITS-1:0]       rem,
   input  logic [FB-1:0]                      free_node,
   output tdi_pkg::walk_out_type              res
);

   logic edge_ok;
   logic free_ok;
   logic room_ok;

   assign edge_ok = (edge_node != '0) &&
                    (tdi_pkg::CMP_BITS'(edge_node) < tdi_pkg::CMP_BITS'(NODES));
   assign free_ok = tdi_pkg::CMP_BITS'(free_node) < tdi_pkg::CMP_BITS'(NODES);
   // rem <= NODES - free, kept free of underflow
   assign room_ok = (tdi_pkg::CMP_BITS'(rem) + tdi_pkg::CMP_BITS'(free_node)) <=
                    tdi_pkg::CMP_BITS'(NODES);

   always_comb begin
      res.failed  = ctl.failed;
      res.growing = ctl.growing;
      res.follow  = 1'b0;
      res.grow    = 1'b0;
      if (!ctl.empty && !ctl.failed) begin
         priority if (ctl.lookup) begin
            if (edge_ok) res.follow = 1'b1;
            else         res.failed = 1'b1;
         end else if (ctl.growing) begin
            if (free_ok) res.grow   = 1'b1;
            else         res.failed = 1'b1;
         end else if (edge_ok) begin
            res.follow = 1'b1;
         end else if (!room_ok) begin
            res.failed = 1'b1;
         end else begin
            res.growing = 1'b1;
            if (free_ok) res.grow   = 1'b1;
            else         res.failed = 1'b1;
         end
      end
   end

endmodule

>>> rtl/trie_dictionary_insert_lookup_top.sv
// Trie dictionary top level: edge table and word counter memories with walk control.
// A non-final item is accepted with an edge table read, then resolved and written.
// A final item also takes the S_COUNT step for the word counter read-modify-write.
// Only a final item yields a result, registered from S_COUNT; while an earlier result
// waits unaccepted, the count step holds and no further item is accepted.
// Reset starts a clearing pass over both memories, during which no item is accepted.
module trie_dictionary_insert_lookup_top #(
   parameter int NODES      = 256,
   parameter int COUNT_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   tdi_req_if.sink     req_if,
   tdi_rsp_if.source   rsp_if
);

   localparam int NB = (NODES > 1) ? $clog2(NODES) : 1;
   localparam int FB = $clog2(NODES + 1);
   localparam int AB = NB + tdi_pkg::SYM_BITS;

   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_EDGE  = 2'd2;
   localparam logic [1:0] S_COUNT = 2'd3;

   logic [NB-1:0]         edge_mem [2**AB];
   logic [COUNT_BITS-1:0] count_mem [2**NB];

   logic [1:0]                      state_ff, state_in;
   logic [AB-1:0]                   clr_ff, clr_in;
   logic [FB-1:0]                   free_ff, free_in;
   logic [NB-1:0]                   cur_ff, cur_in;
   logic                            in_word_ff, in_word_in;
   logic                            lookup_ff, lookup_in;
   logic                            growing_ff, growing_in;
   logic                            failed_ff, failed_in;
   logic                            empty_ff, empty_in;
   logic                            last_ff, last_in;
   logic [tdi_pkg::SYM_BITS-1:0]    sym_ff, sym_in;
   logic [tdi_pkg::REM_BITS-1:0]    rem_ff, rem_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            found_ff, found_in;
   logic [tdi_pkg::OCC_BITS-1:0]    occ_ff, occ_in;
   logic                            status_ff, status_in;

   logic [NB-1:0]         edge_rd_ff;
   logic [COUNT_BITS-1:0] cnt_rd_ff;

   logic                  accept;
   logic                  rsp_free;
   logic [NB-1:0]         rd_node;
   logic                  edge_we;
   logic [AB-1:0]         edge_waddr;
   logic [NB-1:0]         edge_wdata;
   logic                  count_we;
   logic [NB-1:0]         count_waddr;
   logic [COUNT_BITS-1:0] count_wdata;
   logic [COUNT_BITS-1:0] cnt_inc;
   logic [COUNT_BITS-1:0] cnt_sel;
   logic [31:0]           cnt_wide;

   tdi_pkg::walk_in_type  walk_ctl;
   tdi_pkg::walk_out_type walk_res;

   assign req_if.ready = (state_ff == S_IDLE);
   assign accept       = req_if.valid && req_if.ready;
   assign rsp_free     = !rsp_valid_ff || rsp_if.ready;

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.found       = found_ff;
   assign rsp_if.occurrences = occ_ff;
   assign rsp_if.status      = status_ff;

   assign rd_node = in_word_ff ? cur_ff : '0;

   assign walk_ctl.lookup  = lookup_ff;
   assign walk_ctl.growing = growing_ff;
   assign walk_ctl.failed  = failed_ff;
   assign walk_ctl.empty   = empty_ff;

   tdi_step #(
      .NODES (NODES),
      .NB    (NB),
      .FB    (FB)
   ) u_step (
      .ctl       (walk_ctl),
      .edge_node (edge_rd_ff),
      .rem       (rem_ff),
      .free_node (free_ff),
      .res       (walk_res)
   );

   assign cnt_inc  = (cnt_rd_ff == {COUNT_BITS{1'b1}}) ? cnt_rd_ff : cnt_rd_ff + 1'b1;
   assign cnt_wide = 32'(cnt_sel);

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      free_in      = free_ff;
      cur_in       = cur_ff;
      in_word_in   = in_word_ff;
      lookup_in    = lookup_ff;
      growing_in   = growing_ff;
      failed_in    = failed_ff;
      empty_in     = empty_ff;
      last_in      = last_ff;
      sym_in       = sym_ff;
      rem_in       = rem_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      found_in     = found_ff;
      occ_in       = occ_ff;
      status_in    = status_ff;
      edge_we      = 1'b0;
      edge_waddr   = {cur_ff, sym_ff};
      edge_wdata   = free_ff[NB-1:0];
      count_we     = 1'b0;
      count_waddr  = cur_ff;
      count_wdata  = cnt_inc;
      cnt_sel      = '0;

      unique case (state_ff)
         S_CLEAR: begin
            edge_we     = 1'b1;
            edge_waddr  = clr_ff;
            edge_wdata  = '0;
            count_we    = (clr_ff[tdi_pkg::SYM_BITS-1:0] == '0);
            count_waddr = clr_ff[AB-1:tdi_pkg::SYM_BITS];
            count_wdata = '0;
            clr_in      = clr_ff + 1'b1;
            if (clr_ff == {AB{1'b1}}) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) begin
               if (!in_word_ff) begin
                  lookup_in  = req_if.opcode;
                  cur_in     = '0;
                  growing_in = 1'b0;
                  failed_in  = 1'b0;
                  empty_in   = (req_if.chars_remaining == '0);
               end else begin
                  empty_in   = 1'b0;
               end
               sym_in   = req_if.symbol;
               rem_in   = (req_if.chars_remaining == '0) ? tdi_pkg::REM_BITS'(1)
                                                         : req_if.chars_remaining;
               last_in  = (req_if.chars_remaining <= tdi_pkg::REM_BITS'(1));
               state_in = S_EDGE;
            end
         end
         S_EDGE: begin
            failed_in  = walk_res.failed;
            growing_in = walk_res.growing;
            priority if (walk_res.follow) begin
               cur_in = edge_rd_ff;
            end else if (walk_res.grow) begin
               cur_in  = free_ff[NB-1:0];
               free_in = free_ff + 1'b1;
               edge_we = 1'b1;
            end
            if (last_ff) begin
               state_in = S_COUNT;
            end else begin
               in_word_in = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_COUNT: begin
            priority if (lookup_ff) begin
               cnt_sel   = failed_ff ? '0 : cnt_rd_ff;
               found_in  = (cnt_sel != '0);
               status_in = 1'b0;
            end else if (failed_ff) begin
               cnt_sel   = '0;
               found_in  = 1'b0;
               status_in = 1'b1;
            end else begin
               cnt_sel   = cnt_inc;
               found_in  = 1'b1;
               status_in = 1'b0;
            end
            occ_in = (cnt_wide > 32'h0000_FFFF) ? {tdi_pkg::OCC_BITS{1'b1}}
                                                : cnt_wide[tdi_pkg::OCC_BITS-1:0];
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               count_we     = (lookup_ff == tdi_pkg::OP_INSERT) && !failed_ff;
               in_word_in   = 1'b0;
               growing_in   = 1'b0;
               failed_in    = 1'b0;
               cur_in       = '0;
               state_in     = S_IDLE;
            end else begin
               // hold until the waiting result is taken
               found_in  = found_ff;
               occ_in    = occ_ff;
               status_in = status_ff;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         free_ff      <= FB'(1);
         cur_ff       <= '0;
         in_word_ff   <= 1'b0;
         lookup_ff    <= 1'b0;
         growing_ff   <= 1'b0;
         failed_ff    <= 1'b0;
         empty_ff     <= 1'b0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         free_ff      <= free_in;
         cur_ff       <= cur_in;
         in_word_ff   <= in_word_in;
         lookup_ff    <= lookup_in;
         growing_ff   <= growing_in;
         failed_ff    <= failed_in;
         empty_ff     <= empty_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sym_ff    <= sym_in;
      rem_ff    <= rem_in;
      found_ff  <= found_in;
      occ_ff    <= occ_in;
      status_ff <= status_in;
   end

   // edge table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (edge_we) edge_mem[edge_waddr] <= edge_wdata;
      if (accept)  edge_rd_ff <= edge_mem[{rd_node, req_if.symbol}];
   end

   // word counter: read the end node while resolving the last item
   always_ff @(posedge clock) begin
      if (count_we) count_mem[count_waddr] <= count_wdata;
      if (state_ff == S_EDGE) cnt_rd_ff <= count_mem[cur_in];
   end

endmodule

>>> rtl/tdi_checker.sv
// Port-level checks for the trie dictionary top level, bound to it.
module tdi_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_found,
   input logic [tdi_pkg::OCC_BITS-1:0]  rsp_occurrences,
   input logic                          rsp_status
);

   // a waiting result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found) &&
      $stable(rsp_occurrences) && $stable(rsp_status))
      else $error("response changed while stalled");

   a_reject_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> !rsp_found && rsp_occurrences == '0)
      else $error("rejected insert reports a count");

   a_found_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_found == (rsp_occurrences != '0))
      else $error("found disagrees with occurrences");

   // clearing pass and output register start empty
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("activity straight after reset");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item accepted in consecutive cycles");

endmodule

bind trie_dictionary_insert_lookup_top tdi_checker u_tdi_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_if.valid),
   .req_ready       (req_if.ready),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .rsp_found       (rsp_if.found),
   .rsp_occurrences (rsp_if.occurrences),
   .rsp_status      (rsp_if.status)
);
